FILE: hw/rtl/vlmr_pkg.sv
// shared types, constants and helpers of the variable-length message ring
`timescale 1ns / 1ps
`default_nettype none
package vlmr_pkg;

  localparam int BUF_BYTES_DEF    = 4096;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int RING_MIN         = 32;

  localparam int CFG_W  = 13;
  localparam int MODE_W = 2;
  localparam int LEN_W  = 16;
  localparam int CID_W  = 32;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;
  localparam int MOD_W  = 17;

  localparam logic [CFG_W-1:0]  RING_RESET = 13'd4096;
  localparam logic [31:0]       RING_MAGIC = 32'hABCD1234;
  localparam logic [BYTE_W-1:0] FLAG_DONE  = 8'h01;

  localparam logic [4:0] HDR_FLAG   = 5'd0;
  localparam logic [4:0] HDR_MAGIC  = 5'd4;
  localparam logic [4:0] HDR_LEN    = 5'd8;
  localparam logic [4:0] HDR_CLIENT = 5'd16;
  localparam int         HDR_USED   = 20;

  localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;

  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_BIG      = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL         = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_OPEN      = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY        = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_READY    = 3'd5;
  localparam logic [STAT_W-1:0] ST_BAD_RECORD   = 3'd6;
  localparam logic [STAT_W-1:0] ST_ALREADY_OPEN = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  msg_length;
    logic [CID_W-1:0]  client_id;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_byte;
    logic [CID_W-1:0]  out_client;
    logic [LEN_W-1:0]  out_length;
    logic              has_data;
    logic              last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_NORM_WP, S_NORM_RP, S_NORM_ORS, S_NORM_OBL, S_NORM_FIX,
    S_DISPATCH, S_OPEN_HDR, S_OPEN_UPD, S_WR_DATA, S_WR_FLAG, S_RD_HDR, S_RD_CHECK,
    S_RD_ADDR, S_RD_ISSUE, S_RD_CAPT, S_RD_ZERO, S_RD_POS, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MOD_WP, MOD_RP, MOD_ORS, MOD_OBL, MOD_RDADDR, MOD_RDPOS
  } mod_sel_t;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_CLEAR, MEM_HDR, MEM_DATA, MEM_FLAG, MEM_READ, MEM_ZERO
  } mem_op_t;

  typedef enum logic {WALK_WP, WALK_RP} walk_src_t;

  typedef struct packed {
    logic      latch;
    logic      res_init;
    logic      mod_run;
    mod_sel_t  mod_sel;
    logic      mod_store;
    logic      norm_fix;
    logic      walk_init;
    walk_src_t walk_src;
    logic      walk_step;
    logic      hdr_capt;
    mem_op_t   mem_op;
    logic      open_upd;
    logic      wr_upd;
    logic      wr_flag;
    logic      rd_ok;
    logic      rd_fail;
    logic      rd_capt;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              disp_fail;
    logic              norm_ok;
    logic              mod_done;
    logic              hdr_last;
    logic              hdr_rd_last;
    logic              zero_last;
    logic              clear_last;
    logic              obl_one;
    logic              chk_fail;
    logic              mlen_zero;
    logic              rd_final;
  } stat_t;

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [4:0] off,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [CID_W-1:0] cid);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (off == HDR_FLAG) begin
      b = (len == '0) ? FLAG_DONE : '0;
    end else if (off[4:2] == HDR_MAGIC[4:2]) begin
      b = RING_MAGIC[{off[1:0], 3'b000} +: BYTE_W];
    end else if (off == HDR_LEN) begin
      b = len[7:0];
    end else if (off == HDR_LEN + 5'd1) begin
      b = len[15:8];
    end else if (off[4:2] == HDR_CLIENT[4:2]) begin
      b = cid[{off[1:0], 3'b000} +: BYTE_W];
    end
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/variable_length_message_ring.sv
// top level of the variable-length message ring
`timescale 1ns / 1ps
`default_nettype none
// Byte ring of ring_bytes bytes (clamped to 32..BUF_BYTES) holding messages, each a
// HEADER_BYTES header plus its data. One item is handled at a time through a single-port
// byte ram, and its result sits in an output register so the next item can be taken while
// it waits. A data write stores its byte and, when it completes the message, also sets
// the done flag; an open writes the header; a read walks the header, then places the data
// byte with the bit-serial modulo unit and fetches it, and a read that frees its message
// zeroes its header and data and makes one more modulo pass; a read of an empty message
// skips the data modulo pass and the byte fetch. The first item after reset or after a
// ring_bytes write first reduces the stored positions. After reset a clearing pass over
// all BUF_BYTES bytes runs before the first item is taken; configuration writes are
// taken at any time.
module variable_length_message_ring import vlmr_pkg::*; #(
  parameter int BUF_BYTES    = BUF_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);
  localparam int AW = $clog2(BUF_BYTES);

  cmd_t              cmd;
  stat_t             stat;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  vlmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  vlmr_dp #(
    .BUF_BYTES    (BUF_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  vlmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/vlmr_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module vlmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/vlmr_ctrl.sv
// sequencer of the message ring: handshakes and per-mode step order
`timescale 1ns / 1ps
`default_nettype none
module vlmr_ctrl import vlmr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mod_sel  = MOD_WP;
    cmd.walk_src = WALK_WP;
    cmd.mem_op   = MEM_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.mem_op    = MEM_CLEAR;
        cmd.walk_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = stat.norm_ok ? S_DISPATCH : S_NORM_WP;
        end
      end
      S_NORM_WP, S_NORM_RP, S_NORM_ORS, S_NORM_OBL: begin
        cmd.mod_run = 1'b1;
        unique case (state)
          S_NORM_WP:  cmd.mod_sel = MOD_WP;
          S_NORM_RP:  cmd.mod_sel = MOD_RP;
          S_NORM_ORS: cmd.mod_sel = MOD_ORS;
          default:    cmd.mod_sel = MOD_OBL;
        endcase
        if (stat.mod_done) begin
          cmd.mod_store = 1'b1;
          unique case (state)
            S_NORM_WP:  state_next = S_NORM_RP;
            S_NORM_RP:  state_next = S_NORM_ORS;
            S_NORM_ORS: state_next = S_NORM_OBL;
            default:    state_next = S_NORM_FIX;
          endcase
        end
      end
      S_NORM_FIX: begin
        cmd.norm_fix = 1'b1;
        state_next   = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd.res_init = 1'b1;
        if (stat.disp_fail) begin
          state_next = S_FINISH;
        end else if (stat.mode == MODE_OPEN) begin
          cmd.walk_init = 1'b1;
          cmd.walk_src  = WALK_WP;
          state_next    = S_OPEN_HDR;
        end else if (stat.mode == MODE_WRITE) begin
          state_next = S_WR_DATA;
        end else begin
          cmd.walk_init = 1'b1;
          cmd.walk_src  = WALK_RP;
          state_next    = S_RD_HDR;
        end
      end
      S_OPEN_HDR: begin
        cmd.mem_op    = MEM_HDR;
        cmd.walk_step = 1'b1;
        if (stat.hdr_last) state_next = S_OPEN_UPD;
      end
      S_OPEN_UPD: begin
        cmd.open_upd = 1'b1;
        state_next   = S_FINISH;
      end
      S_WR_DATA: begin
        cmd.mem_op = MEM_DATA;
        cmd.wr_upd = 1'b1;
        state_next = stat.obl_one ? S_WR_FLAG : S_FINISH;
      end
      S_WR_FLAG: begin
        cmd.mem_op  = MEM_FLAG;
        cmd.wr_flag = 1'b1;
        state_next  = S_FINISH;
      end
      S_RD_HDR: begin
        cmd.mem_op    = MEM_READ;
        cmd.walk_step = 1'b1;
        cmd.hdr_capt  = 1'b1;
        if (stat.hdr_rd_last) state_next = S_RD_CHECK;
      end
      S_RD_CHECK: begin
        if (stat.chk_fail) begin
          cmd.rd_fail = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.rd_ok = 1'b1;
          if (stat.mlen_zero) begin
            cmd.walk_init = 1'b1;
            cmd.walk_src  = WALK_RP;
            state_next    = S_RD_ZERO;
          end else begin
            state_next = S_RD_ADDR;
          end
        end
      end
      S_RD_ADDR: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = MOD_RDADDR;
        if (stat.mod_done) begin
          cmd.mod_store = 1'b1;
          state_next    = S_RD_ISSUE;
        end
      end
      S_RD_ISSUE: begin
        cmd.mem_op = MEM_READ;
        state_next = S_RD_CAPT;
      end
      S_RD_CAPT: begin
        cmd.rd_capt = 1'b1;
        if (stat.rd_final) begin
          cmd.walk_init = 1'b1;
          cmd.walk_src  = WALK_RP;
          state_next    = S_RD_ZERO;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_RD_ZERO: begin
        cmd.mem_op    = MEM_ZERO;
        cmd.walk_step = 1'b1;
        if (stat.zero_last) state_next = S_RD_POS;
      end
      S_RD_POS: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = MOD_RDPOS;
        if (stat.mod_done) begin
          cmd.mod_store = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/vlmr_dp.sv
// datapath of the message ring: positions, modulo unit, header fields, ram port
`timescale 1ns / 1ps
`default_nettype none
module vlmr_dp import vlmr_pkg::*; #(
  parameter int BUF_BYTES    = BUF_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire in_item_t                     in_item,
  input  wire cmd_t                         cmd,
  output stat_t                             stat,
  output out_item_t                         out_item,
  output logic                              mem_we,
  output logic      [$clog2(BUF_BYTES)-1:0] mem_addr,
  output logic      [BYTE_W-1:0]            mem_wdata,
  input  wire logic [BYTE_W-1:0]            mem_rdata
);
  localparam int AW  = $clog2(BUF_BYTES);
  localparam int SW  = AW + 1;
  localparam int HR  = (HEADER_BYTES < HDR_USED) ? HEADER_BYTES : HDR_USED;
  localparam int MSW = $clog2(MOD_W + 2);

  logic [CFG_W-1:0]  ring_bytes;
  logic [SW-1:0]     rb;
  logic [AW-1:0]     wp_raw, rp_raw, ors_raw;
  logic [AW-1:0]     wpn, rpn, orsn, oblm, dptr, ad;
  logic [LEN_W-1:0]  obl, rbd;
  logic              open_active, norm_ok;
  logic [SW-1:0]     used;
  logic [MOD_W-1:0]  cnt;
  in_item_t          item;

  logic [BYTE_W-1:0] flag;
  logic [31:0]       magic;
  logic [LEN_W-1:0]  mlen;
  logic [CID_W-1:0]  mcl;

  logic [STAT_W-1:0] st;
  logic [BYTE_W-1:0] ob;
  logic [CID_W-1:0]  oc;
  logic [LEN_W-1:0]  ol;
  logic              hd, ls;

  logic [MOD_W-1:0]  mval, mod_in;
  logic [SW-1:0]     mrem;
  logic [MSW-1:0]    mstep;
  logic [SW:0]       trial, trial_red;
  logic              mod_done;
  logic [AW-1:0]     mod_res;

  logic [MOD_W-1:0]  open_total, rd_total;
  logic [MOD_W:0]    w_sum, w_red;
  logic [SW:0]       h_sum, h_red, f_sum, f_red;
  logic [SW-1:0]     ad_inc, dp_inc;
  logic [AW-1:0]     ad_next, dp_next;
  logic [4:0]        coff;
  logic [STAT_W-1:0] disp_st, chk_st;

  always_comb begin
    if (ring_bytes < CFG_W'(RING_MIN)) begin
      rb = SW'(RING_MIN);
    end else if (32'(ring_bytes) > 32'(BUF_BYTES)) begin
      rb = SW'(BUF_BYTES);
    end else begin
      rb = SW'(ring_bytes);
    end
  end

  assign open_total = MOD_W'(HEADER_BYTES) + MOD_W'(item.msg_length);
  assign rd_total   = MOD_W'(HEADER_BYTES) + MOD_W'(mlen);

  always_comb begin
    unique case (cmd.mod_sel)
      MOD_WP:     mod_in = MOD_W'(wp_raw);
      MOD_RP:     mod_in = MOD_W'(rp_raw);
      MOD_ORS:    mod_in = MOD_W'(ors_raw);
      MOD_OBL:    mod_in = MOD_W'(obl);
      MOD_RDADDR: mod_in = MOD_W'(rpn) + MOD_W'(HEADER_BYTES) + MOD_W'(rbd);
      MOD_RDPOS:  mod_in = MOD_W'(rpn) + rd_total;
      default:    mod_in = '0;
    endcase
  end

  assign trial     = {mrem, mval[MOD_W-1]};
  assign trial_red = (trial >= (SW+1)'(rb)) ? trial - (SW+1)'(rb) : trial;
  assign mod_done  = (mstep == MSW'(MOD_W + 1));
  assign mod_res   = mrem[AW-1:0];

  assign w_sum = (MOD_W+1)'(wpn) + (MOD_W+1)'(open_total);
  assign w_red = (w_sum >= (MOD_W+1)'(rb)) ? w_sum - (MOD_W+1)'(rb) : w_sum;
  assign h_sum = (SW+1)'(wpn) + (SW+1)'(HEADER_BYTES);
  assign h_red = (h_sum >= (SW+1)'(rb)) ? h_sum - (SW+1)'(rb) : h_sum;
  assign f_sum = (SW+1)'(wpn) + (SW+1)'(rb) - (SW+1)'(oblm);
  assign f_red = (f_sum >= (SW+1)'(rb)) ? f_sum - (SW+1)'(rb) : f_sum;

  assign ad_inc  = SW'(ad) + SW'(1);
  assign ad_next = (ad_inc == rb) ? '0 : ad_inc[AW-1:0];
  assign dp_inc  = SW'(dptr) + SW'(1);
  assign dp_next = (dp_inc == rb) ? '0 : dp_inc[AW-1:0];
  assign coff    = cnt[4:0] - 5'd1;

  always_comb begin
    disp_st = ST_OK;
    unique case (item.mode)
      MODE_OPEN: begin
        if (open_active) begin
          disp_st = ST_ALREADY_OPEN;
        end else if (open_total > MOD_W'(rb)) begin
          disp_st = ST_TOO_BIG;
        end else if ((MOD_W+1)'(used) + (MOD_W+1)'(open_total) > (MOD_W+1)'(rb)) begin
          disp_st = ST_FULL;
        end
      end
      MODE_WRITE: begin
        if (!open_active) disp_st = ST_NO_OPEN;
      end
      default: begin
        if (used == '0) disp_st = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    chk_st = ST_OK;
    if (flag != FLAG_DONE) begin
      chk_st = ST_NOT_READY;
    end else if (magic != RING_MAGIC || rd_total > MOD_W'(used) || rbd > mlen ||
                 (mlen != '0 && rbd == mlen)) begin
      chk_st = ST_BAD_RECORD;
    end
  end

  always_comb begin
    stat.mode        = item.mode;
    stat.disp_fail   = (disp_st != ST_OK);
    stat.norm_ok     = norm_ok;
    stat.mod_done    = mod_done;
    stat.hdr_last    = (cnt == MOD_W'(HEADER_BYTES - 1));
    stat.hdr_rd_last = (cnt == MOD_W'(HR));
    stat.zero_last   = (cnt == rd_total - MOD_W'(1));
    stat.clear_last  = (cnt == MOD_W'(BUF_BYTES - 1));
    stat.obl_one     = (obl == LEN_W'(1));
    stat.chk_fail    = (chk_st != ST_OK);
    stat.mlen_zero   = (mlen == '0);
    stat.rd_final    = ((MOD_W'(rbd) + MOD_W'(1)) == MOD_W'(mlen));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ad;
    mem_wdata = '0;
    unique case (cmd.mem_op)
      MEM_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = cnt[AW-1:0];
      end
      MEM_HDR: begin
        mem_we    = 1'b1;
        mem_wdata = hdr_byte(cnt[4:0], item.msg_length, item.client_id);
      end
      MEM_DATA: begin
        mem_we    = 1'b1;
        mem_addr  = dptr;
        mem_wdata = item.data_byte;
      end
      MEM_FLAG: begin
        mem_we    = 1'b1;
        mem_addr  = orsn;
        mem_wdata = FLAG_DONE;
      end
      MEM_ZERO: mem_we = 1'b1;
      MEM_READ, MEM_NONE: mem_we = 1'b0;
      default: mem_we = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_bytes  <= RING_RESET;
      wp_raw      <= '0;
      rp_raw      <= '0;
      ors_raw     <= '0;
      obl         <= '0;
      rbd         <= '0;
      used        <= '0;
      open_active <= 1'b0;
      norm_ok     <= 1'b0;
      cnt         <= '0;
      mstep       <= '0;
    end else begin
      if (cfg_we) begin
        ring_bytes <= cfg_data;
        norm_ok    <= 1'b0;
      end
      if (cmd.norm_fix) norm_ok <= 1'b1;
      if (cmd.mod_run) begin
        mstep <= mod_done ? '0 : mstep + MSW'(1);
      end
      if (cmd.walk_init) begin
        cnt <= '0;
      end else if (cmd.walk_step) begin
        cnt <= cnt + MOD_W'(1);
      end
      if (cmd.open_upd) begin
        ors_raw     <= wpn;
        wp_raw      <= AW'(w_red);
        used        <= used + SW'(open_total);
        obl         <= item.msg_length;
        open_active <= (item.msg_length != '0);
      end
      if (cmd.wr_upd) obl <= obl - LEN_W'(1);
      if (cmd.wr_flag) open_active <= 1'b0;
      if (cmd.rd_capt) rbd <= rbd + LEN_W'(1);
      if (cmd.mod_store && cmd.mod_sel == MOD_RDPOS) begin
        rp_raw <= mod_res;
        used   <= used - SW'(rd_total);
        rbd    <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) item <= in_item;
    if (cmd.mod_run && !mod_done) begin
      if (mstep == '0) begin
        mval <= mod_in;
        mrem <= '0;
      end else begin
        mval <= mval << 1;
        mrem <= trial_red[SW-1:0];
      end
    end
    if (cmd.mod_store) begin
      unique case (cmd.mod_sel)
        MOD_WP:     wpn  <= mod_res;
        MOD_RP:     rpn  <= mod_res;
        MOD_ORS:    orsn <= mod_res;
        MOD_OBL:    oblm <= mod_res;
        MOD_RDADDR: ad   <= mod_res;
        MOD_RDPOS: begin
          rpn <= mod_res;
          ls  <= 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.norm_fix) dptr <= AW'(f_red);
    if (cmd.walk_init) begin
      ad <= (cmd.walk_src == WALK_WP) ? wpn : rpn;
    end else if (cmd.walk_step) begin
      ad <= ad_next;
    end
    if (cmd.open_upd) begin
      orsn <= wpn;
      wpn  <= AW'(w_red);
      dptr <= AW'(h_red);
    end
    if (cmd.wr_upd) dptr <= dp_next;
    if (cmd.res_init) begin
      st    <= disp_st;
      ob    <= '0;
      oc    <= '0;
      ol    <= '0;
      hd    <= 1'b0;
      ls    <= 1'b0;
      flag  <= '0;
      magic <= '0;
      mlen  <= '0;
      mcl   <= '0;
    end
    if (cmd.hdr_capt && cnt != '0) begin
      if (coff == HDR_FLAG) begin
        flag <= mem_rdata;
      end else if (coff[4:2] == HDR_MAGIC[4:2]) begin
        magic[{coff[1:0], 3'b000} +: BYTE_W] <= mem_rdata;
      end else if (coff == HDR_LEN) begin
        mlen[7:0] <= mem_rdata;
      end else if (coff == HDR_LEN + 5'd1) begin
        mlen[15:8] <= mem_rdata;
      end else if (coff[4:2] == HDR_CLIENT[4:2]) begin
        mcl[{coff[1:0], 3'b000} +: BYTE_W] <= mem_rdata;
      end
    end
    if (cmd.rd_fail) st <= chk_st;
    if (cmd.rd_ok) begin
      oc <= mcl;
      ol <= mlen;
    end
    if (cmd.rd_capt) begin
      ob <= mem_rdata;
      hd <= 1'b1;
    end
    if (cmd.load_out) begin
      out_item <= '{status: st, out_byte: ob, out_client: oc, out_length: ol,
                    has_data: hd, last: ls};
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/vlmr_checker.sv
// port checks of the message ring and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none
module vlmr_checker import vlmr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result item changed");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |->
      !out_item.has_data && !out_item.last && out_item.out_byte == '0)
    else $error("failed item carries data");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.has_data |-> out_item.out_byte == '0)
    else $error("byte without has_data");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");
endmodule

bind variable_length_message_ring vlmr_checker u_chk (.*);
`default_nettype wire

FILE: test/vlmr_checker.sv
// checker that predicts and compares the results of the message ring
`timescale 1ns / 1ps
module vlmr_scoreboard import vlmr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_item,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  localparam int unsigned BUF = BUF_BYTES_DEF;
  localparam int unsigned HDR = HEADER_BYTES_DEF;

  logic [7:0]       ring_mem [BUF];
  logic [CFG_W-1:0] ring_reg;
  int unsigned      rd_pos, wr_pos, used, open_start, open_left, rd_done;
  bit               open_on;
  out_item_t        expected_q[$];

  assign pending = expected_q.size();

  function automatic int unsigned ring_size();
    int unsigned r;
    r = ring_reg;
    if (r < RING_MIN) r = RING_MIN;
    if (r > BUF) r = BUF;
    return r;
  endfunction

  function automatic out_item_t next_result(in_item_t it);
    out_item_t   res;
    int unsigned rb, total, wp, rp, pos, magic, mlen, mcl;
    res = '0;
    rb = ring_size();
    if (it.mode == MODE_OPEN) begin
      total = HDR + it.msg_length;
      if (open_on) res.status = ST_ALREADY_OPEN;
      else if (total > rb) res.status = ST_TOO_BIG;
      else if (used + total > rb) res.status = ST_FULL;
      else begin
        wp = wr_pos % rb;
        for (int i = 0; i < HDR; i++) ring_mem[(wp + i) % rb] = 8'h00;
        for (int i = 0; i < 4; i++) begin
          ring_mem[(wp + 4 + i) % rb] = RING_MAGIC[8*i +: 8];
          ring_mem[(wp + 16 + i) % rb] = it.client_id[8*i +: 8];
        end
        ring_mem[(wp + 8) % rb] = it.msg_length[7:0];
        ring_mem[(wp + 9) % rb] = it.msg_length[15:8];
        open_start = wp;
        wr_pos = (wp + total) % rb;
        used += total;
        open_left = it.msg_length;
        if (it.msg_length == 0) begin
          ring_mem[wp] = FLAG_DONE;
          open_on = 0;
        end else begin
          open_on = 1;
        end
      end
    end else if (it.mode == MODE_WRITE) begin
      if (!open_on) res.status = ST_NO_OPEN;
      else begin
        wp = wr_pos % rb;
        pos = (wp + rb - (open_left % rb)) % rb;
        ring_mem[pos] = it.data_byte;
        open_left = (open_left - 1) & 16'hFFFF;
        if (open_left == 0) begin
          ring_mem[open_start % rb] = FLAG_DONE;
          open_on = 0;
        end
      end
    end else begin
      if (used == 0) res.status = ST_EMPTY;
      else begin
        rp = rd_pos % rb;
        if (ring_mem[rp] != FLAG_DONE) res.status = ST_NOT_READY;
        else begin
          magic = 0;
          mcl = 0;
          for (int i = 0; i < 4; i++) begin
            magic |= ring_mem[(rp + 4 + i) % rb] << (8 * i);
            mcl |= ring_mem[(rp + 16 + i) % rb] << (8 * i);
          end
          mlen = ring_mem[(rp + 8) % rb] | (ring_mem[(rp + 9) % rb] << 8);
          if (magic != RING_MAGIC || HDR + mlen > used || rd_done > mlen ||
              (mlen != 0 && rd_done == mlen)) begin
            res.status = ST_BAD_RECORD;
          end else begin
            res.out_client = mcl;
            res.out_length = LEN_W'(mlen);
            if (mlen != 0) begin
              res.out_byte = ring_mem[(rp + HDR + rd_done) % rb];
              res.has_data = 1;
              rd_done++;
            end
            if (rd_done == mlen) begin
              total = HDR + mlen;
              for (int i = 0; i < total; i++) ring_mem[(rp + i) % rb] = 8'h00;
              rd_pos = (rp + total) % rb;
              used -= total;
              rd_done = 0;
              res.last = 1;
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
      ring_reg = RING_RESET;
      rd_pos = 0; wr_pos = 0; used = 0;
      open_start = 0; open_left = 0; open_on = 0; rd_done = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) ring_reg = cfg_data;
      if (in_valid && !in_stall) expected_q.push_back(next_result(in_item));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with no item waiting");
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("status", e.status, out_item.status);
          check_field("out_byte", e.out_byte, out_item.out_byte);
          check_field("out_client", e.out_client, out_item.out_client);
          check_field("out_length", e.out_length, out_item.out_length);
          check_field("has_data", e.has_data, out_item.has_data);
          check_field("last", e.last, out_item.last);
        end
      end
    end
  end

endmodule

FILE: test/tb.sv
// testbench top of the message ring: stimulus, reset and verdict
`timescale 1ns / 1ps
module tb;
  import vlmr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ALT_READ = 2'd3;
  localparam int IDLE_LIMIT = 200000;

  logic             clk = 0;
  logic             rst = 1;
  logic             in_valid = 0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 0;
  out_item_t        out_item;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  int               errors, pending;
  bit               calm = 0;
  int               quiet_cycles = 0;

  variable_length_message_ring DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  vlmr_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 37);
  end

  // watchdog on cycles with no accepted item, result or configuration write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[variable_length_message_ring] ERROR");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [MODE_W-1:0] m, logic [LEN_W-1:0] len,
                                  logic [CID_W-1:0] cid, logic [BYTE_W-1:0] d);
    in_item_t it;
    it.mode = m;
    it.msg_length = len;
    it.client_id = cid;
    it.data_byte = d;
    return it;
  endfunction

  task automatic send(in_item_t it);
    if (!calm && $urandom_range(99) < 37) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_ring(logic [CFG_W-1:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic rand_item();
    send(mk(MODE_W'($urandom_range(0, 3)), LEN_W'($urandom_range(4073, 65535)), $urandom,
            BYTE_W'($urandom)));
  endtask

  // open, fill and drain messages with random content, sometimes broken
  task automatic message_burst(int max_len, inout int count);
    int n, len, k;
    int lens[$];
    n = $urandom_range(1, 3);
    for (int m = 0; m < n; m++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(0, max_len) : $urandom_range(0, 8);
      if (len > max_len) len = max_len;
      lens.push_back(len);
      send(mk(MODE_OPEN, LEN_W'(len), $urandom, BYTE_W'($urandom)));
      count++;
      k = ($urandom_range(9) == 0) ? $urandom_range(0, len) : len;
      for (int b = 0; b < k; b++) begin
        send(mk(MODE_WRITE, LEN_W'($urandom), $urandom, BYTE_W'($urandom)));
        count++;
      end
      if ($urandom_range(4) == 0) begin
        rand_item();
        count++;
      end
    end
    foreach (lens[i]) begin
      k = (lens[i] == 0) ? 1 : lens[i];
      for (int b = 0; b < k; b++) begin
        send(mk($urandom_range(1) ? MODE_READ : MODE_ALT_READ, LEN_W'($urandom), $urandom,
                BYTE_W'($urandom)));
        count++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] sizes[6];
    int count, per_phase, max_len;
    sizes = '{13'd0, 13'd8191, 13'd100, 13'd32, 13'd4096, 13'd0};
    sizes[5] = CFG_W'($urandom_range(33, 4095));
    repeat (6) @(posedge clk);
    rst <= 0;

    send(mk(MODE_READ, 16'h0000, 32'h0, 8'h00));
    send(mk(MODE_WRITE, 16'h0000, 32'h0, 8'hFF));
    send(mk(MODE_OPEN, 16'h0000, 32'hFFFFFFFF, 8'h00));
    send(mk(MODE_READ, 16'h0000, 32'h0, 8'h00));
    send(mk(MODE_ALT_READ, 16'hFFFF, 32'h0, 8'h00));
    send(mk(MODE_OPEN, 16'hFFFF, 32'h12345678, 8'h00));
    send(mk(MODE_OPEN, 16'd4073, 32'h0, 8'h00));
    write_ring(13'd32);
    send(mk(MODE_OPEN, 16'd8, 32'h00000000, 8'h00));
    send(mk(MODE_OPEN, 16'd0, 32'h1, 8'h00));
    send(mk(MODE_READ, 16'd0, 32'h0, 8'h00));
    for (int b = 0; b < 8; b++) send(mk(MODE_WRITE, 16'd0, 32'h0, b[0] ? 8'hFF : 8'h00));
    send(mk(MODE_OPEN, 16'd0, 32'h2, 8'h00));
    for (int b = 0; b < 8; b++) send(mk(MODE_READ, 16'd0, 32'h0, 8'h00));

    per_phase = 500 / 6;
    foreach (sizes[p]) begin
      write_ring(sizes[p]);
      calm = (p == 2);
      max_len = (sizes[p] < 32) ? 8 : (sizes[p] > 4096) ? 80 : sizes[p] - 24;
      if (max_len > 80) max_len = 80;
      count = 0;
      while (count < per_phase) begin
        if ($urandom_range(6) == 0) begin
          rand_item();
          count++;
        end else begin
          message_burst(max_len, count);
        end
      end
    end
    calm = 0;

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[variable_length_message_ring] OK");
    end else begin
      $display("[variable_length_message_ring] ERROR");
    end
    $finish;
  end

endmodule

FILE: variable_length_message_ring.f
hw/rtl/vlmr_pkg.sv
hw/rtl/vlmr_ram.sv
hw/rtl/vlmr_ctrl.sv
hw/rtl/vlmr_dp.sv
hw/rtl/variable_length_message_ring.sv
hw/rtl/vlmr_checker.sv
test/vlmr_checker.sv
test/tb.sv
